// ===== hdl/escape_sequence_decoder_assert.svh =====
// assertion macros used by the bound checker file
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// checked only outside reset
`define ESD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset as well
`define ESD_CHECK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/esd_pkg.sv =====
package esd_pkg;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNC_ESC = 2'd1;
	localparam logic [1:0] ST_TRUNC_HEX = 2'd2;
	localparam logic [1:0] ST_BAD_HEX   = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       out_last;
	} out_item_t;

	// classified byte handed from the front to the back
	typedef struct packed {
		logic [7:0] raw;
		logic       last;
		logic       is_bslash;
		logic       is_x;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic [7:0] esc_val;
	} cls_t;

endpackage

// ===== hdl/esd_front.sv =====
module esd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  esd_pkg::in_item_t byte_item,
	output logic              push_valid,
	input  logic              push_ready,
	output esd_pkg::cls_t     push_item
);
	import esd_pkg::*;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;
	logic [7:0] diff;

	always_comb begin
		cls_d           = '0;
		cls_d.raw       = byte_item.in_byte;
		cls_d.last      = byte_item.in_last;
		cls_d.is_bslash = (byte_item.in_byte == CH_BSLASH);
		cls_d.is_x      = (byte_item.in_byte == CH_X);
		diff            = 8'h00;
		case (byte_item.in_byte) inside
			[CH_0:CH_9]: begin
				diff          = byte_item.in_byte - CH_0;
				cls_d.hex_ok  = 1'b1;
				cls_d.hex_val = diff[3:0];
			end
			[CH_LA:CH_LF]: begin
				diff          = byte_item.in_byte - CH_LA + 8'd10;
				cls_d.hex_ok  = 1'b1;
				cls_d.hex_val = diff[3:0];
			end
			[CH_UA:CH_UF]: begin
				diff          = byte_item.in_byte - CH_UA + 8'd10;
				cls_d.hex_ok  = 1'b1;
				cls_d.hex_val = diff[3:0];
			end
			default: begin
				cls_d.hex_ok  = 1'b0;
				cls_d.hex_val = 4'h0;
			end
		endcase
		case (byte_item.in_byte)
			CH_A:    cls_d.esc_val = 8'h07;
			CH_B:    cls_d.esc_val = 8'h08;
			CH_T:    cls_d.esc_val = 8'h09;
			CH_N:    cls_d.esc_val = 8'h0A;
			CH_V:    cls_d.esc_val = 8'h0B;
			CH_F:    cls_d.esc_val = 8'h0C;
			CH_R:    cls_d.esc_val = 8'h0D;
			default: cls_d.esc_val = byte_item.in_byte;
		endcase
	end

	assign byte_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

// ===== hdl/esd_fifo.sv =====
module esd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  esd_pkg::cls_t push_item,
	output logic          pop_valid,
	input  logic          pop_ready,
	output esd_pkg::cls_t pop_item
);
	import esd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/esd_back.sv =====
module esd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  esd_pkg::cls_t      pop_item,
	output logic               res_valid,
	input  logic               res_ready,
	output esd_pkg::out_item_t res_item
);
	import esd_pkg::*;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_HEX_HI = 4'b0100,
		MODE_HEX_LO = 4'b1000
	} mode_t;

	mode_t     mode_q;
	mode_t     mode_d;
	logic [3:0] nibble_q;
	logic       nibble_we;
	logic       emit;
	out_item_t  res_d;
	logic       res_valid_q;
	out_item_t  res_q;
	logic       take;
	logic       do_pop;

	// output register frees up when empty or being drained
	assign take      = !res_valid_q || res_ready;
	assign pop_ready = take;
	assign do_pop    = pop_valid && take;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_comb begin
		mode_d    = mode_q;
		nibble_we = 1'b0;
		emit      = 1'b0;
		res_d     = '{out_byte: 8'h00, status: ST_OK, out_last: pop_item.last};
		case (mode_q)
			MODE_NORMAL: begin
				if (pop_item.is_bslash) begin
					if (pop_item.last) begin
						emit         = 1'b1;
						res_d.status = ST_TRUNC_ESC;
					end else begin
						mode_d = MODE_ESCAPE;
					end
				end else begin
					emit           = 1'b1;
					res_d.out_byte = pop_item.raw;
				end
			end
			MODE_ESCAPE: begin
				if (pop_item.is_x) begin
					if (pop_item.last) begin
						emit         = 1'b1;
						res_d.status = ST_TRUNC_HEX;
						mode_d       = MODE_NORMAL;
					end else begin
						mode_d = MODE_HEX_HI;
					end
				end else begin
					emit           = 1'b1;
					res_d.out_byte = pop_item.esc_val;
					mode_d         = MODE_NORMAL;
				end
			end
			MODE_HEX_HI: begin
				if (!pop_item.hex_ok) begin
					emit         = 1'b1;
					res_d.status = ST_BAD_HEX;
					mode_d       = MODE_NORMAL;
				end else if (pop_item.last) begin
					emit         = 1'b1;
					res_d.status = ST_TRUNC_HEX;
					mode_d       = MODE_NORMAL;
				end else begin
					nibble_we = 1'b1;
					mode_d    = MODE_HEX_LO;
				end
			end
			MODE_HEX_LO: begin
				emit   = 1'b1;
				mode_d = MODE_NORMAL;
				if (!pop_item.hex_ok) begin
					res_d.status = ST_BAD_HEX;
				end else begin
					res_d.out_byte = {nibble_q, pop_item.hex_val};
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			nibble_q    <= 4'h0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				mode_q <= mode_d;
				if (nibble_we) begin
					nibble_q <= pop_item.hex_val;
				end
			end
			if (take) begin
				res_valid_q <= do_pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && emit) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== hdl/escape_sequence_decoder.sv =====
// channel  direction  handshake               payload
// byte     in         byte_valid/byte_ready   byte_item (in_byte, in_last)
// res      out        res_valid/res_ready     res_item (out_byte, status, out_last)
//
// one byte per clock while res is not stalled; with an empty queue a byte passes
// through the classify stage, the queue, then decode and the output register
// a byte that only advances an escape yields no result transfer
// arst_n clears the stage valid, queue pointers, decode mode and output valid
// a stall on res backs up the output register, then the queue, then the front
// stage, and only then drops byte_ready
module escape_sequence_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  esd_pkg::in_item_t  byte_item,
	output logic               res_valid,
	input  logic               res_ready,
	output esd_pkg::out_item_t res_item
);
	import esd_pkg::*;

	logic push_valid;
	logic push_ready;
	cls_t push_item;
	logic pop_valid;
	logic pop_ready;
	cls_t pop_item;

	esd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	esd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	esd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

// ===== hdl/escape_sequence_decoder_chk.sv =====
`include "escape_sequence_decoder_assert.svh"

module escape_sequence_decoder_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input esd_pkg::out_item_t res_item
);
	import esd_pkg::*;

	`ESD_CHECK(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_item), "result changed while stalled")
	`ESD_CHECK(a_err_zero, res_valid && res_item.status != ST_OK |-> res_item.out_byte == 8'h00, "error result carries nonzero byte")
	`ESD_CHECK(a_trunc_last, res_valid && (res_item.status == ST_TRUNC_ESC || res_item.status == ST_TRUNC_HEX) |-> res_item.out_last, "truncation result not marked last")
	// the output register may still be unknown at the very first edge of reset
	`ESD_CHECK_RST(a_rst_idle, !arst_n |=> !res_valid, "result valid during reset")

endmodule

bind escape_sequence_decoder escape_sequence_decoder_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_item  (res_item)
);

// ===== test/escape_sequence_decoder_tb_pkg.sv =====
package escape_sequence_decoder_tb_pkg;

	// characters with a meaning inside an escaped string
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_A         = 8'h61;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_V         = 8'h76;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_R         = 8'h72;

endpackage

// ===== test/escape_sequence_decoder_checker.sv =====
module escape_sequence_decoder_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_ready,
	input  esd_pkg::in_item_t  byte_item,
	input  logic               res_valid,
	input  logic               res_ready,
	input  esd_pkg::out_item_t res_item,
	output int                 mismatches,
	output int                 pending,
	output int                 results_seen,
	output int                 error_results
);

	import esd_pkg::*;
	import escape_sequence_decoder_tb_pkg::*;

	typedef enum logic [1:0] {
		DEC_PLAIN,
		DEC_ESC,
		DEC_HEX_HI,
		DEC_HEX_LO
	} dec_mode_e;

	localparam logic [7:0] CC_BEL = 8'h07;
	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_HT  = 8'h09;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_VT  = 8'h0B;
	localparam logic [7:0] CC_FF  = 8'h0C;
	localparam logic [7:0] CC_CR  = 8'h0D;

	dec_mode_e  mode = DEC_PLAIN;
	logic [3:0] hi_nib = 4'h0;
	out_item_t  decoded_q[$];

	initial begin
		mismatches = 0;
		pending = 0;
		results_seen = 0;
		error_results = 0;
	end

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b0, 4'(c - "0")};
		end
		if (c >= "a" && c <= "f") begin
			return {1'b0, 4'(c - "a" + 10)};
		end
		if (c >= "A" && c <= "F") begin
			return {1'b0, 4'(c - "A" + 10)};
		end
		return 5'h10;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			CH_A: return CC_BEL;
			CH_B: return CC_BS;
			CH_T: return CC_HT;
			CH_N: return CC_LF;
			CH_V: return CC_VT;
			CH_F: return CC_FF;
			CH_R: return CC_CR;
			default: return c;
		endcase
	endfunction

	task automatic decode_byte(input in_item_t it);
		logic [4:0] h;
		h = hex_nibble(it.in_byte);
		case (mode)
			DEC_PLAIN: begin
				if (it.in_byte == CH_BACKSLASH) begin
					if (it.in_last) begin
						decoded_q.push_back(out_item_t'{8'h00, ST_TRUNC_ESC, 1'b1});
					end else begin
						mode = DEC_ESC;
					end
				end else begin
					decoded_q.push_back(out_item_t'{it.in_byte, ST_OK, it.in_last});
				end
			end
			DEC_ESC: begin
				if (it.in_byte == CH_X && !it.in_last) begin
					mode = DEC_HEX_HI;
				end else begin
					mode = DEC_PLAIN;
					if (it.in_byte == CH_X) begin
						decoded_q.push_back(out_item_t'{8'h00, ST_TRUNC_HEX, 1'b1});
					end else begin
						decoded_q.push_back(out_item_t'{unescape(it.in_byte), ST_OK, it.in_last});
					end
				end
			end
			DEC_HEX_HI: begin
				if (h[4]) begin
					mode = DEC_PLAIN;
					decoded_q.push_back(out_item_t'{8'h00, ST_BAD_HEX, it.in_last});
				end else if (it.in_last) begin
					mode = DEC_PLAIN;
					decoded_q.push_back(out_item_t'{8'h00, ST_TRUNC_HEX, 1'b1});
				end else begin
					hi_nib = h[3:0];
					mode = DEC_HEX_LO;
				end
			end
			default: begin
				mode = DEC_PLAIN;
				if (h[4]) begin
					decoded_q.push_back(out_item_t'{8'h00, ST_BAD_HEX, it.in_last});
				end else begin
					decoded_q.push_back(out_item_t'{{hi_nib, h[3:0]}, ST_OK, it.in_last});
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			// results trail their bytes through registered stages, so check before predicting
			if (res_valid && res_ready) begin
				results_seen++;
				if (res_item.status != ST_OK) begin
					error_results++;
				end
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result transfer: byte %h status %0d last %b",
							res_item.out_byte, res_item.status, res_item.out_last);
					end
				end else begin
					want = decoded_q.pop_front();
					if (res_item.out_byte !== want.out_byte || res_item.status !== want.status ||
						res_item.out_last !== want.out_last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch: expected byte %h status %0d last %b, got byte %h status %0d last %b",
								want.out_byte, want.status, want.out_last,
								res_item.out_byte, res_item.status, res_item.out_last);
						end
					end
				end
			end
			if (byte_valid && byte_ready) begin
				decode_byte(byte_item);
			end
			pending = decoded_q.size();
		end
	end

endmodule

// ===== test/escape_sequence_decoder_tb.sv =====
module escape_sequence_decoder_tb;

	import esd_pkg::*;
	import escape_sequence_decoder_tb_pkg::*;

	localparam int TARGET_BYTES = 1450;
	localparam int QUIET_FROM   = 1250;
	localparam int HOLD_FROM    = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_ready;
	in_item_t  byte_item = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_item_t res_item;

	int mismatches;
	int pending;
	int results_seen;
	int error_results;
	int bytes_sent = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit sender_idles = 1'b0;

	logic [7:0] str_q[$];

	escape_sequence_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	escape_sequence_decoder_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_item     (res_item),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.error_results(error_results)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall bursts in phases, plus one long hold-off on request
	initial begin
		bit stall_phase;
		int phase_left;
		stall_phase = 1'b0;
		phase_left = 0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				stall_phase = $urandom_range(0, 2) != 0;
				phase_left = $urandom_range(50, 400);
			end else begin
				phase_left--;
			end
			if (hold_req) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				res_ready = 1'b1;
			end else if (!quiet && stall_phase && $urandom_range(0, 5) == 0) begin
				res_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				res_ready = 1'b1;
			end else begin
				res_ready = 1'b1;
			end
		end
	end

	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10) begin
			return 8'("0" + v);
		end
		return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	function automatic logic [7:0] bad_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (is_hex_char(c));
		return c;
	endfunction

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(0, 6))
			0: return CH_A;
			1: return CH_B;
			2: return CH_T;
			3: return CH_N;
			4: return CH_V;
			5: return CH_F;
			default: return CH_R;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic push_byte(input logic [7:0] b, input logic l);
		if (sender_idles && !quiet && $urandom_range(0, 6) == 0) begin
			byte_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		byte_item = in_item_t'{b, l};
		byte_valid = 1'b1;
		do @(posedge clk); while (!byte_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_string();
		foreach (str_q[i]) begin
			push_byte(str_q[i], i == str_q.size() - 1);
		end
		str_q.delete();
	endtask

	task automatic add_token();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			str_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 55) begin
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(escape_letter());
		end else if (kind < 80) begin
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(CH_X);
			str_q.push_back(hex_char(4'($urandom_range(0, 15))));
			str_q.push_back(hex_char(4'($urandom_range(0, 15))));
		end else if (kind < 88) begin
			// literal escape of any byte, may also start a hex escape
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 95) begin
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(CH_X);
			if ($urandom_range(0, 1)) begin
				str_q.push_back(hex_char(4'($urandom_range(0, 15))));
			end
			str_q.push_back(bad_hex_char());
		end else begin
			str_q.push_back(CH_BACKSLASH);
			str_q.push_back(CH_BACKSLASH);
		end
	endtask

	initial begin
		int ntok;
		bit hold_done;
		hold_done = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes, every named escape, mixed-case hex
		str_q = {8'h00, 8'hFF, CH_BACKSLASH, CH_A, CH_BACKSLASH, CH_B, CH_BACKSLASH, CH_T,
			CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_V, CH_BACKSLASH, CH_F, CH_BACKSLASH, CH_R,
			CH_BACKSLASH, CH_X, 8'h61, 8'h46};
		send_string();
		// bad first digit, then the next byte decodes as plain
		str_q = {CH_BACKSLASH, CH_X, 8'h67, 8'h41};
		send_string();
		// truncation at the end of a string
		str_q = {CH_BACKSLASH};
		send_string();
		str_q = {CH_BACKSLASH, CH_X};
		send_string();
		str_q = {CH_BACKSLASH, CH_X, 8'h33};
		send_string();

		while (bytes_sent < TARGET_BYTES) begin
			if (bytes_sent >= QUIET_FROM) begin
				quiet = 1'b1;
			end
			if (!hold_done && bytes_sent >= HOLD_FROM) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			sender_idles = $urandom_range(0, 2) != 0 && !hold_req;
			ntok = $urandom_range(1, 10);
			repeat (ntok) add_token();
			// cut the string off inside an escape now and then
			if ($urandom_range(0, 9) == 0) begin
				str_q.push_back(CH_BACKSLASH);
				if ($urandom_range(0, 1)) begin
					str_q.push_back(CH_X);
					if ($urandom_range(0, 1)) begin
						str_q.push_back(hex_char(4'($urandom_range(0, 15))));
					end
				end
			end
			send_string();
		end
		byte_valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("%0d bytes in %0d results out, %0d of them error reports", bytes_sent,
			results_seen, error_results);
		$display("random stalls on both sides and one %0d cycle hold-off on the result side",
			HOLD_CYCLES);
		if (mismatches == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
